>>> src/trip_pkg.sv
// Package for the thruster reversal interlock: word types, register indexes,
// direction and phase codes. No dependencies.
package trip_pkg;

	typedef struct packed {
		logic [31:0] now_us;
		logic [6:0]  main_pct;
		logic [1:0]  main_dir;
		logic [6:0]  bow_pct;
		logic [1:0]  bow_dir;
		logic [6:0]  rudder_pct;
		logic [1:0]  rudder_dir;
	} trip_in_t;

	typedef struct packed {
		logic [11:0] main_compare;
		logic [11:0] bow_compare;
		logic [11:0] rudder_compare;
		logic [2:0]  phase;
	} trip_out_t;

	// configuration register indexes
	localparam logic [2:0] REG_MAIN_BASE   = 3'd0;
	localparam logic [2:0] REG_BOW_BASE    = 3'd1;
	localparam logic [2:0] REG_RUDDER_BASE = 3'd2;
	localparam logic [2:0] REG_MAIN_SPAN   = 3'd3;
	localparam logic [2:0] REG_BOW_SPAN    = 3'd4;
	localparam logic [2:0] REG_RUDDER_SPAN = 3'd5;
	localparam logic [2:0] REG_DWELL_US    = 3'd6;

	// register reset values
	localparam logic [11:0] MAIN_BASE_RST   = 12'd309;
	localparam logic [11:0] BOW_BASE_RST    = 12'd309;
	localparam logic [11:0] RUDDER_BASE_RST = 12'd287;
	localparam logic [6:0]  MAIN_SPAN_RST   = 7'd20;
	localparam logic [6:0]  BOW_SPAN_RST    = 7'd41;
	localparam logic [6:0]  RUDDER_SPAN_RST = 7'd100;
	localparam logic [19:0] DWELL_US_RST    = 20'd50000;

	// direction codes; everything else is neutral
	localparam logic [1:0] DIR_NEG     = 2'd0;
	localparam logic [1:0] DIR_NEUTRAL = 2'd1;
	localparam logic [1:0] DIR_POS     = 2'd2;

	// phase codes as reported in the result word
	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_MAIN_STOP = 3'd1;
	localparam logic [2:0] PH_MAIN_RUN  = 3'd2;
	localparam logic [2:0] PH_BOW_STOP  = 3'd3;
	localparam logic [2:0] PH_BOW_RUN   = 3'd4;

	// floor(x / 100) for x < 2^14 is (x * 5243) >> 19
	localparam logic [12:0] DIV100_RECIP = 13'd5243;
	localparam int          DIV100_SHIFT = 19;

endpackage

>>> src/trip_drive.sv
// One channel's compare value: base plus signed, scaled and optionally
// clamped offset, saturated to 0..4095. Uses trip_pkg.
module trip_drive
	import trip_pkg::*;
(
	input  logic [11:0] base,
	input  logic [6:0]  span,
	input  logic [13:0] prod,      // pct * span, registered upstream
	input  logic [1:0]  dir,
	input  logic        clamp_en,
	output logic [11:0] compare
);

	logic [26:0] scaled;
	logic [7:0]  mag_raw;
	logic [7:0]  mag;
	logic [13:0] base_x;
	logic [13:0] sum;

	assign scaled  = {13'd0, prod} * {14'd0, DIV100_RECIP};
	assign mag_raw = scaled[DIV100_SHIFT +: 8];
	assign mag     = (clamp_en && (mag_raw > {1'b0, span})) ? {1'b0, span} : mag_raw;
	assign base_x  = {2'b00, base};

	always_comb begin
		case (dir)
			DIR_NEG: begin
				sum = base_x - {6'd0, mag};
			end
			DIR_POS: begin
				sum = base_x + {6'd0, mag};
			end
			default: begin
				sum = base_x;
			end
		endcase
	end

	// sum spans -161..4256: sign bit means below zero, bit 12 means above 4095
	always_comb begin
		if (sum[13]) begin
			compare = 12'd0;
		end else if (sum[12]) begin
			compare = 12'hFFF;
		end else begin
			compare = sum[11:0];
		end
	end

endmodule

>>> src/thruster_reversal_interlock_pwm_core.sv
// Top level of the thruster reversal interlock and PWM compare generator.
// Depends on trip_pkg and trip_drive.

// One result word per input word, one input word per clock sustained while the
// output is not stalled. An input word is taken into an input register (with the
// three 7x7 percent-times-span products already formed), then one pass of logic
// scales by 1/100, clamps main and bow, saturates and steps the reversal
// sequencer into the result register. The result register frees as it is taken,
// so in_ready stays high under a stalled output only until the input register
// also fills. Configuration writes are always accepted and must only be made
// while the block is idle; there is no clearing pass after reset.
module thruster_reversal_interlock_pwm_core
	import trip_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  trip_in_t    in_data,

	output logic        out_valid,
	input  logic        out_ready,
	output trip_out_t   out_data,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE      = 5'b00001,
		ST_MAIN_STOP = 5'b00010,
		ST_MAIN_RUN  = 5'b00100,
		ST_BOW_STOP  = 5'b01000,
		ST_BOW_RUN   = 5'b10000
	} trip_state_t;

	// configuration
	logic [11:0] main_base_q, bow_base_q, rudder_base_q;
	logic [6:0]  main_span_q, bow_span_q, rudder_span_q;
	logic [19:0] dwell_us_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_base_q   <= MAIN_BASE_RST;
			bow_base_q    <= BOW_BASE_RST;
			rudder_base_q <= RUDDER_BASE_RST;
			main_span_q   <= MAIN_SPAN_RST;
			bow_span_q    <= BOW_SPAN_RST;
			rudder_span_q <= RUDDER_SPAN_RST;
			dwell_us_q    <= DWELL_US_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAIN_BASE:   main_base_q   <= cfg_data[11:0];
				REG_BOW_BASE:    bow_base_q    <= cfg_data[11:0];
				REG_RUDDER_BASE: rudder_base_q <= cfg_data[11:0];
				REG_MAIN_SPAN:   main_span_q   <= cfg_data[6:0];
				REG_BOW_SPAN:    bow_span_q    <= cfg_data[6:0];
				REG_RUDDER_SPAN: rudder_span_q <= cfg_data[6:0];
				REG_DWELL_US:    dwell_us_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// input register
	logic        s1_valid_q;
	logic [31:0] now_s1;
	logic [1:0]  main_dir_s1, bow_dir_s1, rudder_dir_s1;
	logic [13:0] main_prod_s1, bow_prod_s1, rudder_prod_s1;
	logic        advance;
	logic        out_valid_q;

	assign advance  = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_s1         <= in_data.now_us;
			main_dir_s1    <= in_data.main_dir;
			bow_dir_s1     <= in_data.bow_dir;
			rudder_dir_s1  <= in_data.rudder_dir;
			main_prod_s1   <= {7'd0, in_data.main_pct} * {7'd0, main_span_q};
			bow_prod_s1    <= {7'd0, in_data.bow_pct} * {7'd0, bow_span_q};
			rudder_prod_s1 <= {7'd0, in_data.rudder_pct} * {7'd0, rudder_span_q};
		end
	end

	// channel drive values
	logic [11:0] main_drv, bow_drv, rudder_drv;

	trip_drive u_main_drive (
		.base     (main_base_q),
		.span     (main_span_q),
		.prod     (main_prod_s1),
		.dir      (main_dir_s1),
		.clamp_en (1'b1),
		.compare  (main_drv)
	);

	trip_drive u_bow_drive (
		.base     (bow_base_q),
		.span     (bow_span_q),
		.prod     (bow_prod_s1),
		.dir      (bow_dir_s1),
		.clamp_en (1'b1),
		.compare  (bow_drv)
	);

	trip_drive u_rudder_drive (
		.base     (rudder_base_q),
		.span     (rudder_span_q),
		.prod     (rudder_prod_s1),
		.dir      (rudder_dir_s1),
		.clamp_en (1'b0),
		.compare  (rudder_drv)
	);

	// sequencer state; the holds double as the result register payload
	trip_state_t state_q, state_d;
	logic [31:0] dwell_start_q, dwell_start_d;
	logic [1:0]  last_main_dir_q, last_main_dir_d;
	logic [1:0]  last_bow_dir_q, last_bow_dir_d;
	logic [11:0] main_hold_q, main_hold_d;
	logic [11:0] bow_hold_q, bow_hold_d;
	logic [11:0] rudder_hold_q;
	logic [31:0] elapsed;
	logic        dwell_done;

	// modular difference, so wrap of the time base is harmless
	assign elapsed    = now_s1 - dwell_start_q;
	assign dwell_done = elapsed > {12'd0, dwell_us_q};

	always_comb begin
		state_d         = state_q;
		dwell_start_d   = dwell_start_q;
		last_main_dir_d = last_main_dir_q;
		last_bow_dir_d  = last_bow_dir_q;
		main_hold_d     = main_hold_q;
		bow_hold_d      = bow_hold_q;
		case (state_q)
			ST_MAIN_STOP: begin
				main_hold_d = main_base_q;
				if (dwell_done) begin
					state_d       = ST_MAIN_RUN;
					dwell_start_d = now_s1;
				end
			end
			ST_MAIN_RUN: begin
				main_hold_d = main_drv;
				if (dwell_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_BOW_STOP: begin
				bow_hold_d = bow_base_q;
				if (dwell_done) begin
					state_d       = ST_BOW_RUN;
					dwell_start_d = now_s1;
				end
			end
			ST_BOW_RUN: begin
				bow_hold_d = bow_drv;
				if (dwell_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				// main wins; a bow change on the same word is picked up later
				if (main_dir_s1 != last_main_dir_q) begin
					state_d         = ST_MAIN_STOP;
					last_main_dir_d = main_dir_s1;
					dwell_start_d   = now_s1;
				end else if (bow_dir_s1 != last_bow_dir_q) begin
					state_d        = ST_BOW_STOP;
					last_bow_dir_d = bow_dir_s1;
					dwell_start_d  = now_s1;
				end else begin
					state_d     = ST_IDLE;
					main_hold_d = main_drv;
					bow_hold_d  = bow_drv;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			dwell_start_q   <= 32'd0;
			last_main_dir_q <= DIR_NEUTRAL;
			last_bow_dir_q  <= DIR_NEUTRAL;
			main_hold_q     <= MAIN_BASE_RST;
			bow_hold_q      <= BOW_BASE_RST;
			rudder_hold_q   <= RUDDER_BASE_RST;
		end else if (advance) begin
			state_q         <= state_d;
			dwell_start_q   <= dwell_start_d;
			last_main_dir_q <= last_main_dir_d;
			last_bow_dir_q  <= last_bow_dir_d;
			main_hold_q     <= main_hold_d;
			bow_hold_q      <= bow_hold_d;
			rudder_hold_q   <= rudder_drv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	logic [2:0] phase_code;

	always_comb begin
		case (state_q)
			ST_MAIN_STOP: phase_code = PH_MAIN_STOP;
			ST_MAIN_RUN:  phase_code = PH_MAIN_RUN;
			ST_BOW_STOP:  phase_code = PH_BOW_STOP;
			ST_BOW_RUN:   phase_code = PH_BOW_RUN;
			default:      phase_code = PH_IDLE;
		endcase
	end

	assign out_valid               = out_valid_q;
	assign out_data.main_compare   = main_hold_q;
	assign out_data.bow_compare    = bow_hold_q;
	assign out_data.rudder_compare = rudder_hold_q;
	assign out_data.phase          = phase_code;

	// both stages full and the output stalled: nothing more may come in
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && out_valid_q && !out_ready |-> !in_ready)
		else $error("input taken while both stages full");

	// a main reversal records the new direction as it starts the stop dwell
	a_main_dir_recorded: assert property (@(posedge clk) disable iff (!arst_n)
		advance && state_q == ST_IDLE && state_d == ST_MAIN_STOP
		|=> last_main_dir_q == $past(main_dir_s1))
		else $error("main direction not recorded on reversal");

	// during the stop dwell the main motor sits at its base
	a_main_stop_base: assert property (@(posedge clk) disable iff (!arst_n)
		advance && state_q == ST_MAIN_STOP |=> main_hold_q == $past(main_base_q))
		else $error("main not held at base during stop dwell");

	// a bow restart dwell only ends in idle
	a_bow_run_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BOW_RUN |=> state_q == ST_BOW_RUN || state_q == ST_IDLE)
		else $error("bow restart left to a state other than idle");

endmodule

>>> tb/sv/testbench.sv
// Regression bench for thruster_reversal_interlock_pwm_core: queued driver, monitor, watchdog.
// Predicts every result word from its own copy of the interlock state and registers.
// Depends on trip_pkg and the core RTL.
module testbench;
	import trip_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REG_UNUSED  = 3'd7;
	localparam int         WATCHDOG_LIMIT = 5000;
	localparam int         LONG_HOLD   = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	trip_in_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	trip_out_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [19:0] cfg_data = '0;

	thruster_reversal_interlock_pwm_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// predictor copy of the registers
	logic [11:0] cfg_main_base   = MAIN_BASE_RST;
	logic [11:0] cfg_bow_base    = BOW_BASE_RST;
	logic [11:0] cfg_rudder_base = RUDDER_BASE_RST;
	logic [6:0]  cfg_main_span   = MAIN_SPAN_RST;
	logic [6:0]  cfg_bow_span    = BOW_SPAN_RST;
	logic [6:0]  cfg_rudder_span = RUDDER_SPAN_RST;
	logic [19:0] cfg_dwell       = DWELL_US_RST;

	// predictor copy of the interlock state
	logic [2:0]  ilk_phase     = PH_IDLE;
	logic [31:0] dwell_mark    = '0;
	logic [1:0]  prev_main_dir = DIR_NEUTRAL;
	logic [1:0]  prev_bow_dir  = DIR_NEUTRAL;
	logic [11:0] main_hold     = MAIN_BASE_RST;
	logic [11:0] bow_hold      = BOW_BASE_RST;
	logic [11:0] rudder_hold   = RUDDER_BASE_RST;

	trip_in_t  pending_words[$];
	trip_out_t expected_words[$];

	int words_queued  = 0;
	int words_taken   = 0;
	int results_taken = 0;
	int fail_count    = 0;
	int send_gap      = 0;
	int send_burst    = 0;
	int stall_left    = 0;
	int take_burst    = 0;
	int hold_off_mark = 150;
	int idle_cycles   = 0;

	logic [31:0] stim_now = '0;
	logic [1:0]  cur_mdir = DIR_NEUTRAL;
	logic [1:0]  cur_bdir = DIR_NEUTRAL;

	function automatic logic [11:0] pwm_compare(input logic [11:0] base, input logic [6:0] span,
			input logic [6:0] pct, input logic [1:0] dir, input bit clamp);
		int mag, lim, off, level;
		mag = (pct * span) / 100;
		lim = span;
		level = base;
		if (dir == DIR_NEG)
			off = -mag;
		else if (dir == DIR_POS)
			off = mag;
		else
			off = 0;
		if (clamp) begin
			if (off > lim)
				off = lim;
			if (off < -lim)
				off = -lim;
		end
		level = level + off;
		if (level < 0)
			level = 0;
		if (level > 4095)
			level = 4095;
		return level[11:0];
	endfunction

	function automatic bit dwell_elapsed(input logic [31:0] now);
		logic [31:0] diff;
		diff = now - dwell_mark;
		return diff > {12'd0, cfg_dwell};
	endfunction

	task automatic advance_interlock(input trip_in_t w);
		trip_out_t r;
		rudder_hold = pwm_compare(cfg_rudder_base, cfg_rudder_span, w.rudder_pct,
			w.rudder_dir, 1'b0);
		case (ilk_phase)
			PH_MAIN_STOP: begin
				main_hold = cfg_main_base;
				if (dwell_elapsed(w.now_us)) begin
					ilk_phase = PH_MAIN_RUN;
					dwell_mark = w.now_us;
				end
			end
			PH_MAIN_RUN: begin
				main_hold = pwm_compare(cfg_main_base, cfg_main_span, w.main_pct, w.main_dir, 1'b1);
				if (dwell_elapsed(w.now_us))
					ilk_phase = PH_IDLE;
			end
			PH_BOW_STOP: begin
				bow_hold = cfg_bow_base;
				if (dwell_elapsed(w.now_us)) begin
					ilk_phase = PH_BOW_RUN;
					dwell_mark = w.now_us;
				end
			end
			PH_BOW_RUN: begin
				bow_hold = pwm_compare(cfg_bow_base, cfg_bow_span, w.bow_pct, w.bow_dir, 1'b1);
				if (dwell_elapsed(w.now_us))
					ilk_phase = PH_IDLE;
			end
			default: begin
				// main wins; a bow change on the same word stays unrecorded
				if (w.main_dir != prev_main_dir) begin
					ilk_phase = PH_MAIN_STOP;
					prev_main_dir = w.main_dir;
					dwell_mark = w.now_us;
				end else if (w.bow_dir != prev_bow_dir) begin
					ilk_phase = PH_BOW_STOP;
					prev_bow_dir = w.bow_dir;
					dwell_mark = w.now_us;
				end else begin
					ilk_phase = PH_IDLE;
					main_hold = pwm_compare(cfg_main_base, cfg_main_span, w.main_pct,
						w.main_dir, 1'b1);
					bow_hold = pwm_compare(cfg_bow_base, cfg_bow_span, w.bow_pct,
						w.bow_dir, 1'b1);
				end
			end
		endcase
		r.main_compare   = main_hold;
		r.bow_compare    = bow_hold;
		r.rudder_compare = rudder_hold;
		r.phase          = ilk_phase;
		expected_words.push_back(r);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				advance_interlock(in_data);
				words_taken++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					in_data <= pending_words.pop_front();
					in_valid <= 1'b1;
					if (send_burst > 0) begin
						send_burst--;
					end else if ($urandom_range(0, 49) == 0) begin
						send_burst = $urandom_range(20, 60);
					end else begin
						send_gap = pick_gap();
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver, with a long hold-off every few hundred words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				results_taken++;
			if (stall_left == 0) begin
				if (results_taken >= hold_off_mark) begin
					stall_left = LONG_HOLD;
					hold_off_mark += 450;
				end else if (take_burst > 0) begin
					take_burst--;
				end else if ($urandom_range(0, 49) == 0) begin
					take_burst = $urandom_range(20, 60);
				end else if ($urandom_range(0, 3) == 0) begin
					stall_left = pick_gap();
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		trip_out_t exp_word;
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				$error("result word with none expected: %h", out_data);
				fail_count++;
			end else begin
				exp_word = expected_words.pop_front();
				if (out_data.main_compare !== exp_word.main_compare) begin
					$error("main_compare: expected %0d, actual %0d",
						exp_word.main_compare, out_data.main_compare);
					fail_count++;
				end
				if (out_data.bow_compare !== exp_word.bow_compare) begin
					$error("bow_compare: expected %0d, actual %0d",
						exp_word.bow_compare, out_data.bow_compare);
					fail_count++;
				end
				if (out_data.rudder_compare !== exp_word.rudder_compare) begin
					$error("rudder_compare: expected %0d, actual %0d",
						exp_word.rudder_compare, out_data.rudder_compare);
					fail_count++;
				end
				if (out_data.phase !== exp_word.phase) begin
					$error("phase: expected %0d, actual %0d", exp_word.phase, out_data.phase);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("thruster_reversal_interlock_pwm_core regression: fail");
			$finish;
		end
	end

	task automatic queue_word(input logic [31:0] step_us, input logic [6:0] mp,
			input logic [1:0] md, input logic [6:0] bp, input logic [1:0] bd,
			input logic [6:0] rp, input logic [1:0] rd);
		trip_in_t w;
		stim_now = stim_now + step_us;
		w.now_us     = stim_now;
		w.main_pct   = mp;
		w.main_dir   = md;
		w.bow_pct    = bp;
		w.bow_dir    = bd;
		w.rudder_pct = rp;
		w.rudder_dir = rd;
		pending_words.push_back(w);
		words_queued++;
	endtask

	// mostly steady directions with occasional reversals; a few noise words
	task automatic queue_random_words(input int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				queue_word($urandom, 7'($urandom), 2'($urandom), 7'($urandom), 2'($urandom),
					7'($urandom), 2'($urandom));
			end else begin
				if ($urandom_range(0, 9) == 0)
					cur_mdir = 2'($urandom);
				if ($urandom_range(0, 9) == 0)
					cur_bdir = 2'($urandom);
				queue_word($urandom_range(0, 2 * cfg_dwell + 2), 7'($urandom), cur_mdir,
					7'($urandom), cur_bdir, 7'($urandom), 2'($urandom));
			end
		end
	endtask

	task automatic drain();
		while (words_taken != words_queued || expected_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MAIN_BASE:   cfg_main_base   = val[11:0];
			REG_BOW_BASE:    cfg_bow_base    = val[11:0];
			REG_RUDDER_BASE: cfg_rudder_base = val[11:0];
			REG_MAIN_SPAN:   cfg_main_span   = val[6:0];
			REG_BOW_SPAN:    cfg_bow_span    = val[6:0];
			REG_RUDDER_SPAN: cfg_rudder_span = val[6:0];
			REG_DWELL_US:    cfg_dwell       = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic set_all(input logic [19:0] mb, input logic [19:0] bb, input logic [19:0] rb,
			input logic [19:0] ms, input logic [19:0] bs, input logic [19:0] rs,
			input logic [19:0] dw);
		write_reg(REG_MAIN_BASE, mb);
		write_reg(REG_BOW_BASE, bb);
		write_reg(REG_RUDDER_BASE, rb);
		write_reg(REG_MAIN_SPAN, ms);
		write_reg(REG_BOW_SPAN, bs);
		write_reg(REG_RUDDER_SPAN, rs);
		write_reg(REG_DWELL_US, dw);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: idle drive, neutral 1 to 3 change, dwell boundary
		queue_word(0, 127, DIR_NEUTRAL, 127, DIR_NEUTRAL, 127, DIR_NEG);
		queue_word(1, 0, DIR_NEUTRAL, 0, DIR_NEUTRAL, 127, DIR_POS);
		queue_word(2, 127, 2'd3, 50, DIR_NEUTRAL, 64, 2'd3);
		queue_word(50000, 127, 2'd3, 50, DIR_NEUTRAL, 64, DIR_NEG);
		queue_word(1, 127, 2'd3, 50, DIR_NEUTRAL, 64, DIR_POS);
		queue_word(10, 127, DIR_POS, 100, DIR_POS, 1, DIR_NEG);
		queue_word(50001, 127, DIR_POS, 100, DIR_NEG, 99, DIR_NEUTRAL);
		drain();

		// saturating settings, short dwell
		set_all(20'd4090, 20'd5, 20'd4095, 20'd100, 20'd100, 20'd100, 20'd10);
		queue_word(0, 127, DIR_POS, 127, DIR_NEG, 127, DIR_POS);
		queue_word(11, 127, DIR_POS, 127, DIR_NEG, 127, DIR_POS);
		queue_word(5, 127, DIR_POS, 127, DIR_NEG, 127, DIR_POS);
		queue_word(6, 127, DIR_NEG, 127, DIR_NEG, 127, DIR_NEG);
		queue_word(1, 127, DIR_POS, 127, DIR_NEG, 0, DIR_NEG);
		queue_word(11, 127, DIR_POS, 127, DIR_NEG, 3, DIR_NEG);
		queue_word(3, 127, DIR_POS, 127, DIR_NEG, 127, DIR_NEG);
		queue_word(20, 127, DIR_NEG, 127, DIR_POS, 5, DIR_POS);
		queue_word(1, 0, DIR_POS, 0, DIR_NEG, 0, DIR_NEUTRAL);
		queue_word(1, 0, DIR_POS, 0, DIR_NEG, 0, DIR_NEUTRAL);
		stim_now = 32'hFFFF_FFF0;
		queue_word(0, 127, DIR_NEG, 127, DIR_POS, 127, 2'd3);
		queue_word(4, 127, DIR_NEG, 127, DIR_POS, 127, 2'd3);
		queue_word(32'hFFFF_FF00, 127, DIR_NEG, 127, DIR_POS, 127, 2'd3);
		queue_word(30, 127, DIR_NEG, 127, DIR_POS, 127, 2'd3);
		queue_word(30, 127, DIR_NEG, 127, DIR_POS, 127, 2'd3);
		drain();

		set_all(20'(MAIN_BASE_RST), 20'(BOW_BASE_RST), 20'(RUDDER_BASE_RST),
			20'(MAIN_SPAN_RST), 20'(BOW_SPAN_RST), 20'(RUDDER_SPAN_RST), DWELL_US_RST);
		queue_random_words(170);
		drain();

		// zero bases, zero dwell; upper data bits set on the narrow registers
		set_all(20'hFF000, 20'hAB000, 20'h55000, 20'(($urandom & 20'hFFF80) | 20'd100),
			20'(($urandom & 20'hFFF80) | 20'd100), 20'(($urandom & 20'hFFF80) | 20'd100),
			20'd0);
		write_reg(REG_UNUSED, 20'($urandom));
		queue_random_words(170);
		drain();

		// top bases, widest spans and dwell, time about to wrap
		set_all(20'd4095, 20'd4095, 20'd4095, 20'd127, 20'd127, 20'd127, 20'hFFFFF);
		stim_now = 32'hFFF0_0000;
		queue_random_words(170);
		drain();

		set_all(20'($urandom), 20'($urandom), 20'($urandom), 20'd0, 20'd0, 20'd0, 20'd5);
		queue_random_words(170);
		drain();

		set_all(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
			20'($urandom), 20'($urandom));
		write_reg(REG_UNUSED, 20'($urandom));
		queue_random_words(170);
		drain();

		set_all(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
			20'($urandom), 20'($urandom_range(0, 300)));
		queue_random_words(170);
		drain();

		if (fail_count == 0)
			$display("thruster_reversal_interlock_pwm_core regression: pass");
		else
			$display("thruster_reversal_interlock_pwm_core regression: fail");
		$finish;
	end

endmodule
